### sv/tcw_pkg.sv
// Shared constants for the text console writer: default geometry, cell codes,
// byte codes and function codes.
// No dependencies.
package tcw_pkg;

    localparam int MEM_WORDS_DEF = 8192;
    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;

    // Widths of the stream fields
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 13;
    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]        TEXT_ATTR  = 8'h07;

    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

endpackage

### sv/text_console_writer.sv
// Text-mode console writer: cell memory, cursor and scroll sequencer.
// Depends on tcw_pkg.
//
// Each request carries one byte to interpret, a clear, or a cell read, and
// returns one result holding the read word, the display start and the cursor
// register. An ordinary byte, backspace, carriage return and DEL finish in the
// execute state; a newline without scroll and a cell read pass one more state. A
// scroll with room left blanks one row through the single memory write port.
// A scroll at the end of memory copies (ROWS-1)*COLUMNS cells, one read and
// one write-back per cell, and then blanks the rest of memory one cell a
// cycle. A clear blanks all MEM_WORDS cells. After reset the block sweeps the
// whole memory to blanks before it takes the first request. A finished result
// waits in an output register while the next request is already taken.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // char_byte[7:0], read_address[20:8], zero pad
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    input  logic        s_axis_tlast,  // end_of_write
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata  // read_data[15:0], screen_start[28:16],
                                      // cursor_register[41:29], zero pad
);

    localparam int AW         = $clog2(MEM_WORDS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int N_COPY     = (ROWS - 1) * COLUMNS;
    localparam int CPW        = $clog2(N_COPY);
    localparam int K_MOD      = N_COPY % MEM_WORDS;
    localparam int TAIL_START = (N_COPY < MEM_WORDS) ? N_COPY : 0;
    localparam int TAIL_REM   = (N_COPY < MEM_WORDS) ? (MEM_WORDS - 1 - N_COPY) : 0;
    localparam bit HAS_TAIL   = (N_COPY < MEM_WORDS);

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_RDWAIT = 8'b0000_1000,
        ST_COPYRD = 8'b0001_0000,
        ST_COPYWR = 8'b0010_0000,
        ST_BLANK  = 8'b0100_0000,
        ST_RET    = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   op_func_reg, op_func_next;
    logic [CHAR_W-1:0]   op_char_reg, op_char_next;
    logic                op_last_reg, op_last_next;
    logic [ADDR_W-1:0]   op_addr_reg, op_addr_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [AW-1:0]       shown_reg, shown_next;
    logic                res_pend_reg, res_pend_next;
    logic [CELL_W-1:0]   res_data_reg, res_data_next;
    logic [AW-1:0]       blk_ptr_reg, blk_ptr_next;
    logic [AW-1:0]       blk_rem_reg, blk_rem_next;
    logic [AW-1:0]       src_ptr_reg, src_ptr_next;
    logic [AW-1:0]       dst_ptr_reg, dst_ptr_next;
    logic [CPW-1:0]      cp_rem_reg, cp_rem_next;
    logic                out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]   out_data_reg, out_data_next;
    logic [ADDR_W-1:0]   out_start_reg, out_start_next;
    logic [ADDR_W-1:0]   out_cursor_reg, out_cursor_next;

    logic [CELL_W-1:0]   mem [MEM_WORDS];
    logic [CELL_W-1:0]   mem_q;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;

    logic                load_ok;
    logic                out_load;
    logic                finish;
    logic                scroll_go;
    logic                room;
    logic                row_last;
    logic                col_wrap;
    logic                addr_in_range;
    logic [AW-1:0]       cur_inc;
    logic [AW-1:0]       cur_dec;
    logic [AW:0]         cur_sum_c;
    logic [AW-1:0]       cur_add_c;
    logic [AW:0]         cur_diff;
    logic [AW-1:0]       cur_ret;
    logic [AW:0]         src_sum;
    logic [AW-1:0]       src_start;

    // Cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    assign load_ok       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!res_pend_reg || load_ok);
    assign out_load      = (state_reg == ST_IDLE) && res_pend_reg && load_ok;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_cursor_reg, out_start_reg, out_data_reg};

    // Offset arithmetic, all modulo MEM_WORDS
    assign cur_inc   = (cursor_reg == AW'(MEM_WORDS - 1)) ? '0 : cursor_reg + 1'b1;
    assign cur_dec   = (cursor_reg == '0) ? AW'(MEM_WORDS - 1) : cursor_reg - 1'b1;
    assign cur_sum_c = {1'b0, cursor_reg} + (AW+1)'(COLUMNS);
    assign cur_add_c = (cur_sum_c >= (AW+1)'(MEM_WORDS))
                       ? AW'(cur_sum_c - (AW+1)'(MEM_WORDS)) : AW'(cur_sum_c);
    assign cur_diff  = {1'b0, cursor_reg} - (AW+1)'(col_reg);
    assign cur_ret   = ({1'b0, cursor_reg} < (AW+1)'(col_reg))
                       ? AW'(cur_diff + (AW+1)'(MEM_WORDS)) : AW'(cur_diff);
    assign src_sum   = {1'b0, base_reg} + (AW+1)'(COLUMNS);
    assign src_start = (src_sum >= (AW+1)'(MEM_WORDS))
                       ? AW'(src_sum - (AW+1)'(MEM_WORDS)) : AW'(src_sum);

    assign room          = (32'(base_reg) + ROWS * COLUMNS + COLUMNS) < MEM_WORDS;
    assign row_last      = (32'(row_reg) + 1) >= ROWS;
    assign col_wrap      = (32'(col_reg) + 1) >= COLUMNS;
    assign addr_in_range = 32'(op_addr_reg) < MEM_WORDS;

    always_comb
    begin
        state_next    = state_reg;
        op_func_next  = op_func_reg;
        op_char_next  = op_char_reg;
        op_last_next  = op_last_reg;
        op_addr_next  = op_addr_reg;
        base_next     = base_reg;
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        shown_next    = shown_reg;
        res_pend_next = res_pend_reg;
        res_data_next = res_data_reg;
        blk_ptr_next  = blk_ptr_reg;
        blk_rem_next  = blk_rem_reg;
        src_ptr_next  = src_ptr_reg;
        dst_ptr_next  = dst_ptr_reg;
        cp_rem_next   = cp_rem_reg;
        mem_we        = 1'b0;
        mem_waddr     = cursor_reg;
        mem_wdata     = BLANK_CELL;
        mem_raddr     = AW'(op_addr_reg);
        finish        = 1'b0;
        scroll_go     = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we       = 1'b1;
                mem_waddr    = blk_ptr_reg;
                blk_ptr_next = blk_ptr_reg + 1'b1;
                blk_rem_next = blk_rem_reg - 1'b1;
                if (blk_rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (out_load)
                begin
                    res_pend_next = 1'b0;
                end
                if (s_axis_tvalid && s_axis_tready)
                begin
                    op_func_next = s_axis_tuser;
                    op_char_next = s_axis_tdata[7:0];
                    op_last_next = s_axis_tlast;
                    op_addr_next = s_axis_tdata[20:8];
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_data_next = '0;
                case (op_func_reg)
                    FN_PUT:
                    begin
                        case (op_char_reg)
                            CH_BS:
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next    = col_reg - 1'b1;
                                    cursor_next = cur_dec;
                                    mem_we      = 1'b1;
                                    mem_waddr   = cur_dec;
                                end
                                finish = 1'b1;
                            end
                            CH_CR:
                            begin
                                cursor_next = cur_ret;
                                col_next    = '0;
                                finish      = 1'b1;
                            end
                            CH_DEL:
                            begin
                                mem_we = 1'b1;
                                finish = 1'b1;
                            end
                            CH_LF:
                            begin
                                cursor_next = cur_add_c;
                                if (!row_last)
                                begin
                                    row_next   = row_reg + 1'b1;
                                    state_next = ST_RET;
                                end
                                else
                                begin
                                    scroll_go = 1'b1;
                                end
                            end
                            default:
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = {TEXT_ATTR, op_char_reg};
                                cursor_next = cur_inc;
                                if (!col_wrap)
                                begin
                                    col_next = col_reg + 1'b1;
                                    finish   = 1'b1;
                                end
                                else
                                begin
                                    col_next = '0;
                                    if (!row_last)
                                    begin
                                        row_next = row_reg + 1'b1;
                                        finish   = 1'b1;
                                    end
                                    else
                                    begin
                                        scroll_go = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                    FN_CLEAR:
                    begin
                        base_next    = '0;
                        cursor_next  = '0;
                        col_next     = '0;
                        row_next     = '0;
                        shown_next   = '0;
                        blk_ptr_next = '0;
                        blk_rem_next = AW'(MEM_WORDS - 1);
                        state_next   = ST_BLANK;
                    end
                    FN_READ:
                    begin
                        state_next = ST_RDWAIT;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase

                if (scroll_go)
                begin
                    if (room)
                    begin
                        // Blank the row below the screen and move the start down
                        blk_ptr_next = AW'(32'(base_reg) + ROWS * COLUMNS);
                        blk_rem_next = AW'(COLUMNS - 1);
                        base_next    = AW'(32'(base_reg) + COLUMNS);
                        state_next   = ST_BLANK;
                    end
                    else
                    begin
                        // Move the lower rows to offset 0, then blank the rest if any remains
                        cursor_next  = AW'(K_MOD);
                        col_next     = '0;
                        base_next    = '0;
                        src_ptr_next = src_start;
                        dst_ptr_next = '0;
                        cp_rem_next  = CPW'(N_COPY - 1);
                        state_next   = ST_COPYRD;
                    end
                end
            end
            ST_RDWAIT:
            begin
                res_data_next = addr_in_range ? mem_q : '0;
                finish        = 1'b1;
            end
            ST_COPYRD:
            begin
                mem_raddr  = src_ptr_reg;
                state_next = ST_COPYWR;
            end
            ST_COPYWR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = dst_ptr_reg;
                mem_wdata    = mem_q;
                src_ptr_next = (src_ptr_reg == AW'(MEM_WORDS - 1)) ? '0 : src_ptr_reg + 1'b1;
                dst_ptr_next = (dst_ptr_reg == AW'(MEM_WORDS - 1)) ? '0 : dst_ptr_reg + 1'b1;
                cp_rem_next  = cp_rem_reg - 1'b1;
                if (cp_rem_reg == '0)
                begin
                    if (HAS_TAIL)
                    begin
                        blk_ptr_next = AW'(TAIL_START);
                        blk_rem_next = AW'(TAIL_REM);
                        state_next   = ST_BLANK;
                    end
                    else
                    begin
                        state_next = ST_RET;
                    end
                end
                else
                begin
                    state_next = ST_COPYRD;
                end
            end
            ST_BLANK:
            begin
                mem_we       = 1'b1;
                mem_waddr    = blk_ptr_reg;
                blk_ptr_next = blk_ptr_reg + 1'b1;
                blk_rem_next = blk_rem_reg - 1'b1;
                if (blk_rem_reg == '0)
                begin
                    if (op_func_reg == FN_CLEAR)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RET;
                    end
                end
            end
            ST_RET:
            begin
                // Carriage return; a no-op when the column is already zero
                cursor_next = cur_ret;
                col_next    = '0;
                finish      = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            res_pend_next = 1'b1;
            state_next    = ST_IDLE;
            if (op_func_reg == FN_PUT && op_last_reg)
            begin
                shown_next = cursor_next;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_start_next  = out_start_reg;
        out_cursor_next = out_cursor_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = res_data_reg;
            out_start_next  = ADDR_W'(base_reg);
            out_cursor_next = ADDR_W'(shown_reg);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            op_func_reg    <= '0;
            op_char_reg    <= '0;
            op_last_reg    <= 1'b0;
            op_addr_reg    <= '0;
            base_reg       <= '0;
            cursor_reg     <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            shown_reg      <= '0;
            res_pend_reg   <= 1'b0;
            res_data_reg   <= '0;
            blk_ptr_reg    <= '0;
            blk_rem_reg    <= AW'(MEM_WORDS - 1);
            src_ptr_reg    <= '0;
            dst_ptr_reg    <= '0;
            cp_rem_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_start_reg  <= '0;
            out_cursor_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_func_reg    <= op_func_next;
            op_char_reg    <= op_char_next;
            op_last_reg    <= op_last_next;
            op_addr_reg    <= op_addr_next;
            base_reg       <= base_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            shown_reg      <= shown_next;
            res_pend_reg   <= res_pend_next;
            res_data_reg   <= res_data_next;
            blk_ptr_reg    <= blk_ptr_next;
            blk_rem_reg    <= blk_rem_next;
            src_ptr_reg    <= src_ptr_next;
            dst_ptr_reg    <= dst_ptr_next;
            cp_rem_reg     <= cp_rem_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_start_reg  <= out_start_next;
            out_cursor_reg <= out_cursor_next;
        end
    end

`ifndef SYNTHESIS
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < MEM_WORDS))
        else $error("cell write outside memory");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cursor_reg) < MEM_WORDS) && (32'(base_reg) < MEM_WORDS)
        && (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS))
        else $error("cursor, start, column or row out of range");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(res_pend_reg && state_reg == ST_IDLE))
        else $error("result shown without a finished request");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!res_pend_reg || out_load))
        else $error("pending result overwritten by next request");
`endif

endmodule
